// ===== design/extended_gcd_defines.svh =====
// ---------------------------------------------------------------------------
// Extended GCD assertion macros
// Shared concurrent assertion forms for the extended GCD block.
// ---------------------------------------------------------------------------
`ifndef EXTENDED_GCD_DEFINES_SVH
`define EXTENDED_GCD_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define EGCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("extended_gcd: assertion failed");

// next-cycle implication, disabled while reset is asserted
`define EGCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("extended_gcd: assertion failed");

`endif

// ===== design/egcd_pkg.sv =====
// ---------------------------------------------------------------------------
// Extended GCD package
// Default operand width and sequencer state codes.
// ---------------------------------------------------------------------------
package egcd_pkg;

    localparam int EGCD_WIDTH = 32;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

endpackage

// ===== design/extended_gcd.sv =====
// ---------------------------------------------------------------------------
// Extended GCD
// GCD and signed Bezout coefficients of two unsigned operands, computed by
// repeated division on one shared bit-serial divide/multiply-accumulate unit.
// ---------------------------------------------------------------------------
// channel  dir  handshake             payload
// s        in   i_s_tvalid/o_s_tready  tdata: first_value, second_value
// m        out  o_m_tvalid/i_m_tready  tdata: gcd_value, coef_first, coef_second
//                                      tuser: zero_error
//
// Each quotient step is a divide pass, one quotient bit per divide step, then an
// update step; an item takes k quotient steps (k <= about 1.44*WIDTH), all run
// on the single step unit. A zero operand goes straight to the final state.
// Reset clears the sequencer and the output valid; no clearing pass.
// A stalled result holds in the output register; the next item is accepted
// meanwhile, and its result waits in the final state until the register frees.
// ---------------------------------------------------------------------------
`include "extended_gcd_defines.svh"

module extended_gcd #(
    parameter int WIDTH = egcd_pkg::EGCD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [WIDTH-1:0] first_value, [2*WIDTH-1:WIDTH] second_value, zero pad
    input  logic [((2*WIDTH+7)/8)*8-1:0]        i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // gcd_value, coef_first, coef_second from bit 0 up, zero pad
    output logic [((3*WIDTH+2+7)/8)*8-1:0]      o_m_tdata,
    // [0] zero_error
    output logic [0:0]                          o_m_tuser
);
    import egcd_pkg::*;

    localparam int OUT_W = ((3*WIDTH+2+7)/8)*8;
    localparam int CW    = $clog2(WIDTH);

    logic [1:0]       r_state, n_state;
    logic [WIDTH-1:0] r_big, n_big;
    logic [WIDTH-1:0] r_small, n_small;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH:0]   r_pb, n_pb;
    logic [WIDTH:0]   r_ps, n_ps;
    logic [WIDTH:0]   r_cbp, n_cbp;
    logic [WIDTH:0]   r_csp, n_csp;
    logic [WIDTH:0]   r_cbc, n_cbc;
    logic [WIDTH:0]   r_csc, n_csc;
    logic             r_swap, n_swap;
    logic             r_err, n_err;
    logic [CW-1:0]    r_cnt, n_cnt;

    logic             r_out_valid, n_out_valid;
    logic [WIDTH-1:0] r_out_gcd, n_out_gcd;
    logic [WIDTH:0]   r_out_cf, n_out_cf;
    logic [WIDTH:0]   r_out_cs, n_out_cs;
    logic             r_out_err, n_out_err;

    logic [WIDTH-1:0] in_a, in_b;
    logic [WIDTH-1:0] step_rem;
    logic [WIDTH:0]   step_pb, step_ps;
    logic             in_acc, out_free;

    assign in_a = i_s_tdata[WIDTH-1:0];
    assign in_b = i_s_tdata[2*WIDTH-1:WIDTH];

    assign o_s_tready = (r_state == S_IDLE);
    assign in_acc     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    egcd_step_unit #(
        .WIDTH (WIDTH)
    ) u_step (
        .i_rem        (r_rem),
        .i_msb        (r_big[WIDTH-1]),
        .i_divisor    (r_small),
        .i_prod_big   (r_pb),
        .i_prod_small (r_ps),
        .i_coef_big   (r_cbc),
        .i_coef_small (r_csc),
        .o_rem        (step_rem),
        .o_prod_big   (step_pb),
        .o_prod_small (step_ps)
    );

    always_comb begin
        n_state     = r_state;
        n_big       = r_big;
        n_small     = r_small;
        n_rem       = r_rem;
        n_pb        = r_pb;
        n_ps        = r_ps;
        n_cbp       = r_cbp;
        n_csp       = r_csp;
        n_cbc       = r_cbc;
        n_csc       = r_csc;
        n_swap      = r_swap;
        n_err       = r_err;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_gcd   = r_out_gcd;
        n_out_cf    = r_out_cf;
        n_out_cs    = r_out_cs;
        n_out_err   = r_out_err;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_err   = (in_a == '0) || (in_b == '0);
                    n_swap  = (in_a < in_b);
                    n_big   = (in_a < in_b) ? in_b : in_a;
                    n_small = (in_a < in_b) ? in_a : in_b;
                    n_rem   = '0;
                    n_pb    = '0;
                    n_ps    = '0;
                    n_cbp   = {{WIDTH{1'b0}}, 1'b1};
                    n_csp   = '0;
                    n_cbc   = '0;
                    n_csc   = {{WIDTH{1'b0}}, 1'b1};
                    n_cnt   = CW'(WIDTH - 1);
                    n_state = n_err ? S_FIN : S_DIV;
                end
            end
            S_DIV: begin
                n_rem = step_rem;
                n_pb  = step_pb;
                n_ps  = step_ps;
                n_big = {r_big[WIDTH-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = S_UPD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_UPD: begin
                if (r_rem == '0) begin
                    n_state = S_FIN;
                end else begin
                    // advance the remainder sequence by one quotient step
                    n_cbp   = r_cbc;
                    n_csp   = r_csc;
                    n_cbc   = r_cbp - r_pb;
                    n_csc   = r_csp - r_ps;
                    n_big   = r_small;
                    n_small = r_rem;
                    n_rem   = '0;
                    n_pb    = '0;
                    n_ps    = '0;
                    n_cnt   = CW'(WIDTH - 1);
                    n_state = S_DIV;
                end
            end
            S_FIN: begin
                // hold until the output register can take the item
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_err   = r_err;
                    n_out_gcd   = r_err ? '0 : r_small;
                    n_out_cf    = r_err ? '0 : (r_swap ? r_csc : r_cbc);
                    n_out_cs    = r_err ? '0 : (r_swap ? r_cbc : r_csc);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_big     <= n_big;
        r_small   <= n_small;
        r_rem     <= n_rem;
        r_pb      <= n_pb;
        r_ps      <= n_ps;
        r_cbp     <= n_cbp;
        r_csp     <= n_csp;
        r_cbc     <= n_cbc;
        r_csc     <= n_csc;
        r_swap    <= n_swap;
        r_err     <= n_err;
        r_cnt     <= n_cnt;
        r_out_gcd <= n_out_gcd;
        r_out_cf  <= n_out_cf;
        r_out_cs  <= n_out_cs;
        r_out_err <= n_out_err;
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = OUT_W'({r_out_cs, r_out_cf, r_out_gcd});
    assign o_m_tuser[0] = r_out_err;

    `EGCD_ASSERT_IMPL(a_div_nonzero, i_clk, i_rst_n, (r_state == S_DIV), (r_small != '0))
    `EGCD_ASSERT_IMPL(a_err_zero_out, i_clk, i_rst_n, (r_out_valid && r_out_err),
        ((r_out_gcd == '0) && (r_out_cf == '0) && (r_out_cs == '0)))
    `EGCD_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, in_acc, (r_state != S_IDLE))
    `EGCD_ASSERT_NEXT(a_fin_load, i_clk, i_rst_n, ((r_state == S_FIN) && out_free),
        (r_out_valid && (r_state == S_IDLE)))

endmodule

// ===== design/egcd_step_unit.sv =====
// ---------------------------------------------------------------------------
// Extended GCD step unit
// One restoring-division bit plus shift-and-add of the quotient bit into
// both coefficient products.
// ---------------------------------------------------------------------------
module egcd_step_unit #(
    parameter int WIDTH = egcd_pkg::EGCD_WIDTH
) (
    input  logic [WIDTH-1:0] i_rem,
    input  logic             i_msb,
    input  logic [WIDTH-1:0] i_divisor,
    input  logic [WIDTH:0]   i_prod_big,
    input  logic [WIDTH:0]   i_prod_small,
    input  logic [WIDTH:0]   i_coef_big,
    input  logic [WIDTH:0]   i_coef_small,
    output logic [WIDTH-1:0] o_rem,
    output logic [WIDTH:0]   o_prod_big,
    output logic [WIDTH:0]   o_prod_small
);
    import egcd_pkg::*;

    logic [WIDTH:0] trial;
    logic [WIDTH:0] diff;
    logic           qbit;

    assign trial = {i_rem, i_msb};
    assign diff  = trial - {1'b0, i_divisor};
    assign qbit  = (trial >= {1'b0, i_divisor});

    assign o_rem = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];

    // products wrap modulo 2^(WIDTH+1), same as the coefficient registers
    assign o_prod_big   = {i_prod_big[WIDTH-1:0], 1'b0}
                          + (qbit ? i_coef_big : {(WIDTH+1){1'b0}});
    assign o_prod_small = {i_prod_small[WIDTH-1:0], 1'b0}
                          + (qbit ? i_coef_small : {(WIDTH+1){1'b0}});

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Extended GCD testbench
// Drives operand pairs into the stream input and predicts the gcd and the
// Bezout coefficients of each pair. Every result is checked against the
// oldest prediction, field by field. The stimulus has directed edge cases,
// random pairs of mixed bit lengths, a run without idling and a run that
// waits for every result before the next item.
// ---------------------------------------------------------------------------
module testbench;

    import egcd_pkg::*;

    localparam int W    = EGCD_WIDTH;
    localparam int SD_W = ((2*W+7)/8)*8;
    localparam int MD_W = ((3*W+2+7)/8)*8;

    typedef struct packed {
        logic [W-1:0] gcd_value;
        logic [W:0]   coef_first;
        logic [W:0]   coef_second;
        logic         zero_error;
    } bezout_t;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_valid = 1'b0;
    logic [SD_W-1:0] s_data = '0;
    logic            m_ready = 1'b0;
    logic            o_s_tready;
    logic            o_m_tvalid;
    // gcd_value, coef_first, coef_second from bit 0 up, zero pad
    logic [MD_W-1:0] o_m_tdata;
    // [0] zero_error
    logic [0:0]      o_m_tuser;

    bezout_t bezout_expected[$];
    int      mismatch_count = 0;
    bit      steady = 1'b0;

    extended_gcd #(.WIDTH(W)) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // gcd and coefficients by the quotient-remainder sequence, larger first
    function automatic bezout_t predict_bezout(logic [W-1:0] a, logic [W-1:0] b);
        bezout_t     res;
        logic [63:0] big, sml, q, rem;
        logic [63:0] cb_prev, cs_prev, cb_cur, cs_cur, cb_new, cs_new;
        logic [63:0] g;
        bit          done;
        res = '0;
        if (a == '0 || b == '0) begin
            res.zero_error = 1'b1;
            return res;
        end
        big = (a < b) ? 64'(b) : 64'(a);
        sml = (a < b) ? 64'(a) : 64'(b);
        cb_prev = 64'd1;
        cs_prev = 64'd0;
        cb_cur  = 64'd0;
        cs_cur  = 64'd1;
        cb_new  = 64'd0;
        cs_new  = 64'd1;
        g = sml;
        done = (big % sml == 64'd0);
        while (!done) begin
            q = big / sml;
            rem = big % sml;
            cb_new = cb_prev - cb_cur * q;
            cs_new = cs_prev - cs_cur * q;
            if (sml % rem == 64'd0) begin
                g = rem;
                done = 1'b1;
            end else begin
                big = sml;
                sml = rem;
                cb_prev = cb_cur;
                cb_cur = cb_new;
                cs_prev = cs_cur;
                cs_cur = cs_new;
            end
        end
        res.gcd_value = g[W-1:0];
        // swap back into operand order
        res.coef_first  = (a < b) ? cs_new[W:0] : cb_new[W:0];
        res.coef_second = (a < b) ? cb_new[W:0] : cs_new[W:0];
        return res;
    endfunction

    // random value of random bit length, full width now and then
    function automatic logic [W-1:0] rand_operand();
        int unsigned len;
        logic [W-1:0] v;
        len = $urandom_range(W, 1);
        v = W'({$urandom, $urandom});
        if (len < W && $urandom_range(15) != 0)
            v = v & ((W'(1) << len) - W'(1));
        return v;
    endfunction

    task automatic send_item(logic [W-1:0] a, logic [W-1:0] b);
        if (!steady && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= SD_W'({b, a});
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        bezout_expected.push_back(predict_bezout(a, b));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (bezout_expected.size() != 0) @(posedge i_clk);
    endtask

    // pair drawn from a mix of special shapes and general values
    task automatic send_random_pair();
        logic [W-1:0] a, b, sml;
        logic [63:0]  k, limit, prod;
        a = rand_operand();
        b = rand_operand();
        case ($urandom_range(19))
            0: begin
                if ($urandom_range(1)) a = '0;
                else b = '0;
            end
            1: b = a;
            2, 3: begin
                sml = a >> $urandom_range(W-1, W/2);
                if (sml == '0) sml = W'(1);
                limit = 64'({W{1'b1}}) / 64'(sml);
                k = 64'({$urandom, $urandom}) % limit + 64'd1;
                prod = 64'(sml) * k;
                if ($urandom_range(1)) begin
                    a = sml;
                    b = prod[W-1:0];
                end else begin
                    a = prod[W-1:0];
                    b = sml;
                end
            end
            default: ;
        endcase
        send_item(a, b);
    endtask

    task automatic test_directed();
        logic [W-1:0] ones;
        ones = '1;
        send_item('0, '0);
        send_item('0, ones);
        send_item(ones, '0);
        send_item(ones, ones);
        send_item(W'(1), W'(1));
        send_item(W'(1), ones);
        send_item(ones, W'(1));
        send_item(ones, ones - W'(1));
        send_item(ones - W'(1), ones);
        send_item(W'(12), W'(36));
        send_item(W'(36), W'(12));
        send_item(W'(240), W'(46));
        send_item(W'(46), W'(240));
        // consecutive Fibonacci numbers give the longest quotient chain
        send_item(W'(32'd1836311903), W'(32'd2971215073));
        send_item(W'(32'd2971215073), W'(32'd1836311903));
        send_item(W'(1) << (W-1), W'(1) << (W/2));
        send_item({1'b1, {(W-1){1'b0}}}, {1'b0, {(W-1){1'b1}}});
        send_item({(W/2){2'b10}}, {(W/2){2'b01}});
        send_item({(W/2){2'b01}}, {(W/2){2'b10}});
        send_item(W'(32'd4294967291), W'(32'd4294967279));
        wait_results_drained();
    endtask

    task automatic test_random_pairs(int count);
        repeat (count) send_random_pair();
    endtask

    task automatic test_no_idling(int count);
        steady = 1'b1;
        repeat (count) send_random_pair();
        wait_results_drained();
        steady = 1'b0;
    endtask

    task automatic test_drained_sender(int count);
        repeat (count) begin
            wait_results_drained();
            send_random_pair();
        end
        wait_results_drained();
    endtask

    // sample results, compare, and drive the receiver's ready at random
    always @(posedge i_clk) begin
        bezout_t got, exp_res;
        if (i_rst_n) begin
            if (o_m_tvalid && m_ready) begin
                got.gcd_value   = o_m_tdata[W-1:0];
                got.coef_first  = o_m_tdata[2*W:W];
                got.coef_second = o_m_tdata[3*W+1:2*W+1];
                got.zero_error  = o_m_tuser[0];
                if (bezout_expected.size() == 0) begin
                    $error("result with no item waiting: gcd_value %0h", got.gcd_value);
                    mismatch_count++;
                end else begin
                    exp_res = bezout_expected.pop_front();
                    if (got.gcd_value !== exp_res.gcd_value) begin
                        $error("gcd_value expected %0d actual %0d",
                               exp_res.gcd_value, got.gcd_value);
                        mismatch_count++;
                    end
                    if (got.coef_first !== exp_res.coef_first) begin
                        $error("coef_first expected %0d actual %0d",
                               $signed(exp_res.coef_first), $signed(got.coef_first));
                        mismatch_count++;
                    end
                    if (got.coef_second !== exp_res.coef_second) begin
                        $error("coef_second expected %0d actual %0d",
                               $signed(exp_res.coef_second), $signed(got.coef_second));
                        mismatch_count++;
                    end
                    if (got.zero_error !== exp_res.zero_error) begin
                        $error("zero_error expected %0b actual %0b",
                               exp_res.zero_error, got.zero_error);
                        mismatch_count++;
                    end
                end
            end
            m_ready <= steady || ($urandom_range(99) >= 12);
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random_pairs(850);
        test_no_idling(250);
        test_random_pairs(50);
        test_drained_sender(80);
        wait_results_drained();
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin
        #100_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
